// ===== hdl/fba_pkg.sv =====
// Shared types, constants and helper functions of the frame bitmap allocator.
package fba_pkg;

	// Bitmap geometry: one bit per frame, two levels of full-word summaries
	localparam int NUM_FRAMES  = 65536;
	localparam int WORD_BITS   = 32;
	localparam int FRAME_W     = 16;
	localparam int WORD_COUNT  = NUM_FRAMES / WORD_BITS;
	localparam int SUM_COUNT   = WORD_COUNT / WORD_BITS;
	localparam int BIT_W       = $clog2(WORD_BITS);
	localparam int WADDR_W     = $clog2(WORD_COUNT);
	localparam int SADDR_W     = $clog2(SUM_COUNT);

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Stream widths
	localparam int CMD_W       = 2;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 24;

	// Frames at or above this have no bitmap bit
	localparam logic [FRAME_W:0] FRAME_LIMIT = (FRAME_W + 1)'(NUM_FRAMES);

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_CLAIM = 2'd2,
		CMD_TEST  = 2'd3
	} cmd_t;

	// Work class decided by the front
	typedef enum logic [2:0] {
		K_ECHO,
		K_ALLOC,
		K_FREE,
		K_CLAIM,
		K_TEST
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic               hit;          // frame has a bitmap bit
		logic [FRAME_W-1:0] frame;        // bitmap frame to free, claim or test
		logic               present;
		logic               writable;
		logic               user;
		logic [FRAME_W-1:0] entry_frame;
		logic               kernel;
		logic               want_wr;
	} op_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_AL1,
		ST_AL0,
		ST_RD,
		ST_UPD,
		ST_DONE
	} state_t;

	// Index of the lowest clear bit of a bitmap word
	function automatic logic [BIT_W-1:0] first_zero_word(input logic [WORD_BITS-1:0] w);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) r = BIT_W'(i);
		end
		return r;
	endfunction

	// Index of the lowest clear bit of the top-level summary
	function automatic logic [SADDR_W-1:0] first_zero_sum(input logic [SUM_COUNT-1:0] w);
		logic [SADDR_W-1:0] r;
		r = '0;
		for (int i = SUM_COUNT - 1; i >= 0; i--) begin
			if (!w[i]) r = SADDR_W'(i);
		end
		return r;
	endfunction

endpackage

// ===== hdl/fba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/fba_front.sv =====
// Front end: takes command beats, classifies them and hands them to the queue.
module fba_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [fba_pkg::CMD_W-1:0]      in_cmd,
	input  logic [fba_pkg::IN_TDATA_W-1:0] in_data,
	input  fba_pkg::back_stat_t            stat,
	output logic                           op_valid_s1,
	output fba_pkg::op_t                   op_s1,
	input  logic                           op_ready
);
	import fba_pkg::*;

	op_t  op_d;
	logic take;

	// Unpack and classify the incoming beat
	always_comb begin
		op_d.present     = in_data[0];
		op_d.writable    = in_data[1];
		op_d.user        = in_data[2];
		op_d.entry_frame = in_data[18:3];
		op_d.kernel      = in_data[35];
		op_d.want_wr     = in_data[36];
		op_d.frame       = in_data[34:19];
		op_d.kind        = K_ECHO;
		unique case (cmd_t'(in_cmd))
			CMD_ALLOC: begin
				op_d.kind = in_data[0] ? K_ECHO : K_ALLOC;
			end
			CMD_FREE: begin
				op_d.frame = in_data[18:3];
				op_d.kind  = (in_data[18:3] == '0) ? K_ECHO : K_FREE;
			end
			CMD_CLAIM: begin
				op_d.kind = K_CLAIM;
			end
			CMD_TEST: begin
				op_d.kind = K_TEST;
			end
		endcase
		op_d.hit = ({1'b0, op_d.frame} < FRAME_LIMIT);
	end

	// No beats while the bitmap is being cleared
	assign in_ready = !stat.clearing && (!op_valid_s1 || op_ready);
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid_s1 <= 1'b0;
		end else if (take) begin
			op_valid_s1 <= 1'b1;
		end else if (op_ready) begin
			op_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) op_s1 <= op_d;
	end

endmodule

// ===== hdl/fba_queue.sv =====
// Short command queue between the front end and the bitmap engine.
module fba_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  fba_pkg::op_t push_op,
	output logic         pop_valid,
	input  logic         pop,
	output fba_pkg::op_t pop_op
);
	import fba_pkg::*;

	op_t               slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_op     = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push_op;
	end

	// Fill count stays within the queue
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue fill count beyond depth");

endmodule

// ===== hdl/fba_back.sv =====
// Bitmap engine: clears, searches and updates the frame bitmap and builds results.
module fba_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            op_valid,
	input  fba_pkg::op_t                    op,
	output logic                            op_pop,
	output fba_pkg::back_stat_t             stat,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [fba_pkg::OUT_TDATA_W-1:0] out_data
);
	import fba_pkg::*;

	state_t               state_q, state_d;
	logic [WADDR_W-1:0]   clr_q;
	op_t                  op_q;
	logic [WADDR_W-1:0]   word_q;
	logic [BIT_W-1:0]     bit_q;
	logic [WORD_BITS-1:0] l0_q;
	logic [WORD_BITS-1:0] l1_q;
	logic                 full_q;
	logic                 used_q;
	logic [SUM_COUNT-1:0] sum_full_q;
	logic                 out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	// RAM ports
	logic                 l0_we, l1_we;
	logic [WADDR_W-1:0]   l0_waddr, l0_raddr;
	logic [SADDR_W-1:0]   l1_waddr, l1_raddr;
	logic [WORD_BITS-1:0] l0_wdata, l1_wdata, l0_rdata, l1_rdata;

	// Update datapath
	logic [SADDR_W-1:0]   sidx;
	logic [BIT_W-1:0]     sbit;
	logic                 set_val;
	logic [WORD_BITS-1:0] mask0, mask1, new_l0, new_l1;
	logic                 new_sum;
	logic                 wr_en;
	logic                 all_full;
	logic [SADDR_W-1:0]   fz_sum;
	logic [BIT_W-1:0]     fz_l1, fz_l0;
	logic                 load_out;

	// Result fields
	logic                 r_present, r_writable, r_user, r_used, r_full;
	logic [FRAME_W-1:0]   r_frame;

	fba_ram #(.WIDTH(WORD_BITS), .DEPTH(WORD_COUNT)) u_l0_ram (
		.clk   (clk),
		.we    (l0_we),
		.waddr (l0_waddr),
		.wdata (l0_wdata),
		.raddr (l0_raddr),
		.rdata (l0_rdata)
	);

	fba_ram #(.WIDTH(WORD_BITS), .DEPTH(SUM_COUNT)) u_l1_ram (
		.clk   (clk),
		.we    (l1_we),
		.waddr (l1_waddr),
		.wdata (l1_wdata),
		.raddr (l1_raddr),
		.rdata (l1_rdata)
	);

	assign stat.clearing = (state_q == ST_CLEAR);
	assign out_valid     = out_valid_q;
	assign out_data      = out_data_q;

	assign all_full = &sum_full_q;
	assign fz_sum   = first_zero_sum(sum_full_q);
	assign fz_l1    = first_zero_word(l1_rdata);
	assign fz_l0    = first_zero_word(l0_rdata);

	// Set or clear one frame bit, then fold the word-full flags upward
	assign sidx    = word_q[BIT_W +: SADDR_W];
	assign sbit    = word_q[BIT_W-1:0];
	assign set_val = (op_q.kind != K_FREE);
	assign mask0   = WORD_BITS'(1) << bit_q;
	assign mask1   = WORD_BITS'(1) << sbit;
	assign new_l0  = set_val ? (l0_q | mask0) : (l0_q & ~mask0);
	assign new_l1  = (&new_l0) ? (l1_q | mask1) : (l1_q & ~mask1);
	assign new_sum = &new_l1;
	assign wr_en   = (op_q.kind == K_ALLOC) ||
		(((op_q.kind == K_FREE) || (op_q.kind == K_CLAIM)) && op_q.hit);

	// Next state and RAM control
	always_comb begin
		state_d  = state_q;
		op_pop   = 1'b0;
		load_out = 1'b0;
		l0_we    = 1'b0;
		l0_waddr = word_q;
		l0_wdata = new_l0;
		l0_raddr = word_q;
		l1_we    = 1'b0;
		l1_waddr = sidx;
		l1_wdata = new_l1;
		l1_raddr = sidx;
		unique case (state_q)
			ST_CLEAR: begin
				l0_we    = 1'b1;
				l0_waddr = clr_q;
				l0_wdata = '0;
				if ({1'b0, clr_q} < (WADDR_W + 1)'(SUM_COUNT)) begin
					l1_we    = 1'b1;
					l1_waddr = clr_q[SADDR_W-1:0];
					l1_wdata = '0;
				end
				if (clr_q == WADDR_W'(WORD_COUNT - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				l0_raddr = op.frame[BIT_W +: WADDR_W];
				l1_raddr = op.frame[BIT_W + BIT_W +: SADDR_W];
				if (op_valid) begin
					op_pop = 1'b1;
					priority case (op.kind)
						K_ECHO: state_d = ST_DONE;
						K_ALLOC: begin
							l1_raddr = fz_sum;
							state_d  = all_full ? ST_DONE : ST_AL1;
						end
						default: state_d = ST_RD;
					endcase
				end
			end
			ST_AL1: begin
				l0_raddr = {sidx, fz_l1};
				state_d  = ST_AL0;
			end
			ST_AL0: state_d = ST_UPD;
			ST_RD:  state_d = ST_UPD;
			ST_UPD: begin
				l0_we   = wr_en;
				l1_we   = wr_en;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Result entry
	always_comb begin
		r_present  = op_q.present;
		r_writable = op_q.writable;
		r_user     = op_q.user;
		r_frame    = op_q.entry_frame;
		r_used     = 1'b0;
		r_full     = 1'b0;
		unique case (op_q.kind)
			K_ALLOC: begin
				if (full_q) begin
					r_full = 1'b1;
				end else begin
					r_present  = 1'b1;
					r_writable = op_q.want_wr;
					r_user     = !op_q.kernel;
					r_frame    = FRAME_W'({word_q, bit_q});
				end
			end
			K_FREE: begin
				r_present = 1'b0;
				r_frame   = '0;
			end
			K_CLAIM: begin
				r_present  = 1'b1;
				r_writable = op_q.want_wr;
				r_user     = !op_q.kernel;
				r_frame    = op_q.frame;
			end
			K_TEST: r_used = used_q;
			default: r_used = 1'b0;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			sum_full_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_UPD && wr_en) sum_full_q[sidx] <= new_sum;
			if (load_out)       out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (op_valid) begin
					op_q   <= op;
					full_q <= (op.kind == K_ALLOC) && all_full;
					bit_q  <= op.frame[BIT_W-1:0];
					if (op.kind == K_ALLOC) word_q <= {fz_sum, BIT_W'(0)};
					else                    word_q <= op.frame[BIT_W +: WADDR_W];
				end
			end
			ST_AL1: begin
				l1_q   <= l1_rdata;
				word_q <= {sidx, fz_l1};
			end
			ST_AL0: begin
				l0_q  <= l0_rdata;
				bit_q <= fz_l0;
			end
			ST_RD: begin
				l0_q   <= l0_rdata;
				l1_q   <= l1_rdata;
				used_q <= l0_rdata[bit_q] && op_q.hit;
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_data_q <= OUT_TDATA_W'({r_full, r_used, r_frame, r_user, r_writable, r_present});
		end
	end

	// The frame picked by an allocation was free
	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && op_q.kind == K_ALLOC) |-> !l0_q[bit_q])
		else $error("allocation picked a used frame");

	// The summary group searched was not full
	a_sum_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AL1) |-> !sum_full_q[sidx])
		else $error("allocation searched a full group");

	// Summary flags move only on a bitmap update
	a_sum_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_UPD) |=> $stable(sum_full_q))
		else $error("summary changed outside update");

endmodule

// ===== hdl/frame_bitmap_allocator_top.sv =====
// Allocate is the longest command from input beat to result beat: summary pick,
//   group word read, bitmap word read, update, result register.
// Commands are handled one at a time by the single bitmap engine, which takes no new one until
//   the last result is loaded; a two-deep queue lets the input side run ahead.
// Reset: asynchronous; afterwards a clearing pass zeroes the bitmap RAMs,
//   during which no input beat is taken.
module frame_bitmap_allocator_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [0] entry_present, [1] entry_writable, [2] entry_user, [18:3] entry_frame,
	// [34:19] target_frame, [35] kernel_only, [36] want_writable, [39:37] zero
	input  logic [fba_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// [1:0] cmd
	input  logic [fba_pkg::CMD_W-1:0]       s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [0] out_present, [1] out_writable, [2] out_user, [18:3] out_frame,
	// [19] frame_used, [20] no_free_frame, [23:21] zero
	output logic [fba_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import fba_pkg::*;

	back_stat_t stat;
	logic       fr_valid, fr_ready;
	op_t        fr_op;
	logic       q_valid, q_pop;
	op_t        q_op;

	fba_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_cmd      (s_axis_tuser),
		.in_data     (s_axis_tdata),
		.stat        (stat),
		.op_valid_s1 (fr_valid),
		.op_s1       (fr_op),
		.op_ready    (fr_ready)
	);

	fba_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_op    (fr_op),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_op     (q_op)
	);

	fba_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (q_valid),
		.op        (q_op),
		.op_pop    (q_pop),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
